FILE: design/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, codes and defaults for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// default sizing
	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned ID_BITS_DEF  = 8;

	// fixed field widths
	localparam int unsigned TIME_W  = 47;
	localparam int unsigned PRIO_W  = 48;
	localparam int unsigned BURN_W  = 32;
	localparam int unsigned RID_W   = 8;
	localparam int unsigned COUNT_W = 5;

	// configuration register indexes
	localparam logic CFG_USE_DEADLINE = 1'b0;
	localparam logic CFG_BURNOUT_MS   = 1'b1;

	// request actions
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_PUSH_FULL  = 2'd1,
		ST_POP_EMPTY  = 2'd2
	} status_t;

	typedef struct packed {
		logic              action;
		logic [RID_W-1:0]  requester_id;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] last_start_ms;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               popped_valid;
		logic [RID_W-1:0]   popped_id;
		logic [PRIO_W-1:0]  popped_priority;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic push_en;
		logic pop_en;
	} cell_ctrl_t;

endpackage

FILE: design/min_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top
// Priority queue ordered by (priority, requester id), lowest first, built
// as a sorted chain of cells that shift together on each push or pop.
// ----------------------------------------------------------------------------
// Done pulses from the result register, which loads as the registered key is applied.
// A new request is not accepted while busy; busy is high for the one cycle
//   in which the registered key is applied to the cell chain.
// The result shows on result for one cycle with done; the receiver cannot stall.
// Reset (arst_n low): queue empty, use_deadline = 0, burnout_ms = 0.
// Entry storage needs no clearing pass; cells carry their own valid bits.
module min_heap_priority_queue_top
	import mhpq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	parameter int unsigned ID_BITS  = ID_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              result,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [BURN_W-1:0] cfg_data
);

	localparam int unsigned KEY_W = PRIO_W + ID_BITS;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// configuration registers
	logic              use_deadline_q;
	logic [BURN_W-1:0] burnout_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_deadline_q <= 1'b0;
			burnout_ms_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_USE_DEADLINE: use_deadline_q <= cfg_data[0];
				CFG_BURNOUT_MS:   burnout_ms_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// stage 1: form the key at accept
	logic              accept;
	logic              busy_s1;
	logic              action_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [PRIO_W-1:0] prio_in;
	logic [ID_BITS-1:0] id_in;

	assign accept = start && !busy_s1;
	assign busy   = busy_s1;
	assign id_in  = ID_BITS'(req.requester_id);

	always_comb begin
		if (use_deadline_q) begin
			prio_in = PRIO_W'(req.last_start_ms) + PRIO_W'(burnout_ms_q);
		end else begin
			prio_in = PRIO_W'(req.now_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= req.action;
			key_s1    <= {prio_in, id_in};
		end
	end

	// occupancy and command decode
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             empty;
	cell_ctrl_t       ctrl;

	assign full         = (count_q == CNT_W'(CAPACITY));
	assign empty        = (count_q == '0);
	assign ctrl.push_en = busy_s1 && (action_s1 == ACT_PUSH) && !full;
	assign ctrl.pop_en  = busy_s1 && (action_s1 == ACT_POP) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push_en) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop_en) begin
			count_q <= count_q - 1'b1;
		end
	end

	// chain of cells; index 0 holds the most urgent entry
	logic             c_valid [CAPACITY];
	logic [KEY_W-1:0] c_key   [CAPACITY];
	logic             c_lt    [CAPACITY];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic             lv;
		logic [KEY_W-1:0] lk;
		logic             llt;
		logic             rv;
		logic [KEY_W-1:0] rk;

		if (g == 0) begin : g_head
			assign lv  = 1'b0;
			assign lk  = '0;
			assign llt = 1'b0;
		end else begin : g_mid_l
			assign lv  = c_valid[g-1];
			assign lk  = c_key[g-1];
			assign llt = c_lt[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign rv = 1'b0;
			assign rk = '0;
		end else begin : g_mid_r
			assign rv = c_valid[g+1];
			assign rk = c_key[g+1];
		end

		mhpq_cell #(
			.KEY_W(KEY_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_key    (key_s1),
			.left_valid (lv),
			.left_key   (lk),
			.left_lt    (llt),
			.right_valid(rv),
			.right_key  (rk),
			.valid      (c_valid[g]),
			.key        (c_key[g]),
			.lt         (c_lt[g])
		);
	end

	// result register
	logic             done_q;
	rsp_t             result_q;
	rsp_t             result_d;
	logic [CNT_W-1:0] count_next;

	always_comb begin
		count_next               = count_q;
		result_d.status          = ST_DONE;
		result_d.popped_valid    = 1'b0;
		result_d.popped_id       = '0;
		result_d.popped_priority = '0;
		if (action_s1 == ACT_PUSH) begin
			if (full) begin
				result_d.status = ST_PUSH_FULL;
			end else begin
				count_next = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				result_d.status = ST_POP_EMPTY;
			end else begin
				count_next               = count_q - 1'b1;
				result_d.popped_valid    = 1'b1;
				result_d.popped_id       = RID_W'(c_key[0][ID_BITS-1:0]);
				result_d.popped_priority = c_key[0][KEY_W-1:ID_BITS];
			end
		end
		result_d.entry_count = COUNT_W'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= busy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: design/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted chain. Holds a key and a valid bit. On push it
// keeps its key, takes the new key, or takes its left neighbor's key; on
// pop it takes its right neighbor's key.
// ----------------------------------------------------------------------------
module mhpq_cell
	import mhpq_pkg::*;
#(
	parameter int unsigned KEY_W = PRIO_W + ID_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [KEY_W-1:0] new_key,
	// left neighbor (more urgent side)
	input  logic             left_valid,
	input  logic [KEY_W-1:0] left_key,
	input  logic             left_lt,
	// right neighbor (less urgent side)
	input  logic             right_valid,
	input  logic [KEY_W-1:0] right_key,
	// own state, seen by both neighbors
	output logic             valid,
	output logic [KEY_W-1:0] key,
	output logic             lt
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;

	// new key belongs at or before this slot
	assign lt    = !valid_q || (new_key < key_q);
	assign valid = valid_q;
	assign key   = key_q;

	// valid bit: grows by one slot on push, shrinks by one on pop; on push
	// a slot fills when its left neighbor shifts in or the new key lands here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop_en) begin
			valid_q <= right_valid;
		end else if (ctrl.push_en) begin
			valid_q <= valid_q || left_valid || (lt && !left_lt);
		end
	end

	// key payload
	always_ff @(posedge clk) begin
		if (ctrl.pop_en) begin
			key_q <= right_key;
		end else if (ctrl.push_en && lt) begin
			key_q <= left_lt ? left_key : new_key;
		end
	end

endmodule

FILE: design/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on request/result timing and result consistency.
// ----------------------------------------------------------------------------
module mhpq_checker
	import mhpq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	// every accepted request yields a result strobe
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result strobe missing two cycles after request");

	// no result without a request before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	// refused operations carry no entry
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_DONE) |-> (!result.popped_valid
			&& result.popped_id == '0 && result.popped_priority == '0))
		else $error("refused request carries popped data");

	// an empty-pop refusal means nothing is held
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_POP_EMPTY) |-> (result.entry_count == '0))
		else $error("pop refused while entries are held");

endmodule

bind min_heap_priority_queue_top mhpq_checker u_mhpq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
